/* design/cndt_pkg.sv */
// Shared types, constants and direction-bin functions of the Canny suppression core.
package cndt_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int HEIGHT_CAP     = 256;
    localparam int MIN_DIM        = 3;
    localparam int CFG_DIM_W      = 9;
    localparam int MARGIN_W       = 7;
    localparam int MAG_W          = 17;
    localparam int GRAD_W         = 16;
    localparam int ROW_W          = 8;
    localparam int APB_ADDR_W     = 5;
    localparam int APB_DATA_W     = 32;
    localparam int RES_FIFO_DEPTH = 3;
    localparam int FIFO_CNT_W     = 2;
    localparam int FIFO_PTR_W     = 2;
    localparam int SLOPE_SCALE    = 10000;
    localparam int SLOPE_LO       = 4142;
    localparam int SLOPE_HI       = 24142;

    typedef logic [MAG_W-1:0] mag_t;

    typedef enum logic [1:0] {
        DIR_HORZ    = 2'd0,
        DIR_DIAG_UL = 2'd1,
        DIR_DIAG_UR = 2'd2,
        DIR_VERT    = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        EDGE_NONE   = 2'd0,
        EDGE_WEAK   = 2'd1,
        EDGE_STRONG = 2'd2
    } edge_class_t;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_BORDER_MARGIN = 3'd2,
        REG_HIGH_THRESH   = 3'd3,
        REG_LOW_THRESH    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        mag_t                     grad_mag;
        logic                     frame_start;
    } in_t;

    typedef struct packed {
        logic        is_peak;
        edge_class_t edge_class;
        logic        frame_end;
    } out_t;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] frame_width;
        logic [CFG_DIM_W-1:0] frame_height;
        logic [MARGIN_W-1:0]  border_margin;
        mag_t                 high_thresh;
        mag_t                 low_thresh;
    } cfg_t;

    typedef struct packed {
        mag_t upper;
        mag_t middle;
        dir_t dir;
    } line_t;

    localparam cfg_t CFG_RESET = '{
        frame_width:   9'd256,
        frame_height:  9'd256,
        border_margin: 7'd1,
        high_thresh:   17'd0,
        low_thresh:    17'd0
    };

    function automatic logic slope_le(input logic signed [GRAD_W:0] y,
                                      input logic signed [GRAD_W:0] x,
                                      input logic signed [15:0] k);
        logic signed [32:0] lhs;
        logic signed [32:0] rhs;
        logic               le;
        lhs = 33'(y) * 33'(SLOPE_SCALE);
        rhs = 33'(k) * 33'(x);
        if (x == '0) begin
            le = (k > 16'sd0) ? (y <= 17'sd0) : (y < 17'sd0);
        end else begin
            le = (lhs <= rhs);
        end
        return le;
    endfunction

    function automatic dir_t dir_bin(input logic signed [GRAD_W-1:0] gx,
                                     input logic signed [GRAD_W-1:0] gy);
        logic signed [GRAD_W:0] x;
        logic signed [GRAD_W:0] y;
        logic                   le_a;
        logic                   le_na;
        logic                   le_b;
        logic                   le_nb;
        dir_t                   bin;
        if (gx < 16'sd0) begin
            x = -17'(gx);
            y = -17'(gy);
        end else begin
            x = 17'(gx);
            y = 17'(gy);
        end
        le_a  = slope_le(y, x, 16'(SLOPE_LO));
        le_na = slope_le(y, x, 16'(-SLOPE_LO));
        le_b  = slope_le(y, x, 16'(SLOPE_HI));
        le_nb = slope_le(y, x, 16'(-SLOPE_HI));
        if (le_a && !le_na) begin
            bin = DIR_HORZ;
        end else if (!le_a && le_b) begin
            bin = DIR_DIAG_UL;
        end else if (le_na && !le_nb) begin
            bin = DIR_DIAG_UR;
        end else begin
            bin = DIR_VERT;
        end
        return bin;
    endfunction

endpackage

/* design/canny_nonmax_double_threshold_core.sv */
// Top level of the Canny non-maximum suppression and double-threshold core.
// Flow: an accepted pixel is registered into the memory stage (s1); its result, if any,
// is then written into the result queue, and m_valid rises once the queue holds it.
// Throughput: one pixel per clock while s_ready is high, set by the single line memory
// read-modify-write per pixel; a pixel following at the same column gets forwarded data.
// Reset: counters, window, pipeline and result queue clear at once; the line
// memory keeps no reset value and needs no clearing pass.
module canny_nonmax_double_threshold_core #(
    parameter int MAX_WIDTH = cndt_pkg::MAX_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cndt_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output cndt_pkg::out_t                  m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cndt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cndt_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cndt_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import cndt_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = ((WID_W > CFG_DIM_W) ? WID_W : CFG_DIM_W) + 1;

    cfg_t                  cfg;
    logic [FIFO_CNT_W-1:0] fifo_count;

    logic [CMP_W-1:0]      fw_ext;
    logic [CMP_W-1:0]      w_eff;
    logic [CFG_DIM_W-1:0]  h_eff;

    logic                  accept;
    logic [COL_W-1:0]      col_reg;
    logic [COL_W-1:0]      col_next;
    logic [ROW_W-1:0]      row_reg;
    logic [ROW_W-1:0]      row_next;
    logic [COL_W-1:0]      cur_col;
    logic [ROW_W-1:0]      cur_row;
    logic [CMP_W-1:0]      col_inc;

    line_t                 line_mem [MAX_WIDTH];
    line_t                 rd_reg;

    logic                     s1_valid_reg;
    logic [COL_W-1:0]         s1_col_reg;
    logic [ROW_W-1:0]         s1_row_reg;
    logic signed [GRAD_W-1:0] s1_gx_reg;
    logic signed [GRAD_W-1:0] s1_gy_reg;
    mag_t                     s1_mag_reg;

    logic                  fwd_valid_reg;
    logic [COL_W-1:0]      fwd_col_reg;
    line_t                 fwd_line_reg;
    logic                  fwd_hit;
    line_t                 rd_line;
    line_t                 wr_line;

    mag_t                  win_mid_reg   [3];
    mag_t                  win_right_reg [3];
    dir_t                  dir_dly_reg;

    mag_t                  centre;
    mag_t                  nb_a;
    mag_t                  nb_b;
    logic                  emit;
    logic [ROW_W-1:0]      cen_row;
    logic [COL_W-1:0]      cen_col;
    logic                  interior;
    logic                  peak;
    out_t                  res;
    logic                  res_push;

    cndt_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb begin
        fw_ext = CMP_W'(cfg.frame_width);
        if (fw_ext < CMP_W'(MIN_DIM)) begin
            w_eff = CMP_W'(MIN_DIM);
        end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = fw_ext;
        end
        if (cfg.frame_height < CFG_DIM_W'(MIN_DIM)) begin
            h_eff = CFG_DIM_W'(MIN_DIM);
        end else if (cfg.frame_height > CFG_DIM_W'(HEIGHT_CAP)) begin
            h_eff = CFG_DIM_W'(HEIGHT_CAP);
        end else begin
            h_eff = cfg.frame_height;
        end
    end

    assign s_ready = aresetn
                  && ((3'(fifo_count) + 3'(s1_valid_reg)) <= 3'(RES_FIFO_DEPTH - 1));
    assign accept  = s_valid && s_ready;
    assign cur_col = s_data.frame_start ? '0 : col_reg;
    assign cur_row = s_data.frame_start ? '0 : row_reg;
    assign col_inc = CMP_W'(cur_col) + CMP_W'(1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_inc >= w_eff) begin
                col_next = '0;
                if ((CFG_DIM_W'(cur_row) + CFG_DIM_W'(1)) >= h_eff) begin
                    row_next = '0;
                end else begin
                    row_next = cur_row + ROW_W'(1);
                end
            end else begin
                col_next = col_inc[COL_W-1:0];
                row_next = cur_row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= accept;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg <= cur_col;
            s1_row_reg <= cur_row;
            s1_gx_reg  <= s_data.grad_x;
            s1_gy_reg  <= s_data.grad_y;
            s1_mag_reg <= s_data.grad_mag;
        end
        if (s1_valid_reg) begin
            fwd_col_reg  <= s1_col_reg;
            fwd_line_reg <= wr_line;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg <= line_mem[cur_col];
        end
        if (s1_valid_reg) begin
            line_mem[s1_col_reg] <= wr_line;
        end
    end

    assign fwd_hit = fwd_valid_reg && (fwd_col_reg == s1_col_reg);
    assign rd_line = fwd_hit ? fwd_line_reg : rd_reg;

    always_comb begin
        wr_line.upper  = rd_line.middle;
        wr_line.middle = s1_mag_reg;
        wr_line.dir    = dir_bin(s1_gx_reg, s1_gy_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                win_mid_reg[i]   <= '0;
                win_right_reg[i] <= '0;
            end
            dir_dly_reg <= DIR_HORZ;
        end else if (s1_valid_reg) begin
            for (int i = 0; i < 3; i++) begin
                win_mid_reg[i] <= win_right_reg[i];
            end
            win_right_reg[0] <= rd_line.upper;
            win_right_reg[1] <= rd_line.middle;
            win_right_reg[2] <= s1_mag_reg;
            dir_dly_reg      <= rd_line.dir;
        end
    end

    assign centre = win_right_reg[1];

    always_comb begin
        case (dir_dly_reg)
            DIR_HORZ: begin
                nb_a = win_mid_reg[1];
                nb_b = rd_line.middle;
            end
            DIR_DIAG_UL: begin
                nb_a = win_mid_reg[0];
                nb_b = s1_mag_reg;
            end
            DIR_DIAG_UR: begin
                nb_a = win_mid_reg[2];
                nb_b = rd_line.upper;
            end
            default: begin
                nb_a = win_right_reg[0];
                nb_b = win_right_reg[2];
            end
        endcase
    end

    assign emit     = (s1_row_reg >= ROW_W'(2)) && (s1_col_reg >= COL_W'(2));
    assign cen_row  = s1_row_reg - ROW_W'(1);
    assign cen_col  = s1_col_reg - COL_W'(1);
    assign interior = (cen_row >= ROW_W'(cfg.border_margin))
                   && (CMP_W'(cen_col) >= CMP_W'(cfg.border_margin))
                   && ((CFG_DIM_W'(cen_row) + CFG_DIM_W'(cfg.border_margin)) < h_eff)
                   && ((CMP_W'(cen_col) + CMP_W'(cfg.border_margin)) < w_eff);
    assign peak     = interior && (centre > nb_a) && (centre > nb_b);

    always_comb begin
        res.is_peak = peak;
        if (!peak) begin
            res.edge_class = EDGE_NONE;
        end else if (centre > cfg.high_thresh) begin
            res.edge_class = EDGE_STRONG;
        end else if (centre < cfg.low_thresh) begin
            res.edge_class = EDGE_NONE;
        end else begin
            res.edge_class = EDGE_WEAK;
        end
        res.frame_end = (CFG_DIM_W'(s1_row_reg) == (h_eff - CFG_DIM_W'(1)))
                     && (CMP_W'(s1_col_reg) == (w_eff - CMP_W'(1)));
    end

    assign res_push = s1_valid_reg && emit;

    cndt_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res),
        .count     (fifo_count),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTHESIS
    a_s1_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> s1_valid_reg)
        else $error("accepted transaction did not reach the memory stage");

    a_no_queue_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> (fifo_count < FIFO_CNT_W'(RES_FIFO_DEPTH)))
        else $error("result pushed into a full queue");

    a_forward_on_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && fwd_hit) |-> $past(s_data.frame_start))
        else $error("same line entry touched twice without a frame restart");
`endif

endmodule

/* design/cndt_apb_regs.sv */
// APB configuration register file of the Canny suppression core.
module cndt_apb_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cndt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cndt_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cndt_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output cndt_pkg::cfg_t                  cfg
);
    import cndt_pkg::*;

    cfg_t     cfg_reg;
    cfg_reg_t reg_sel;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_FRAME_WIDTH:   cfg_reg.frame_width   <= pwdata[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT:  cfg_reg.frame_height  <= pwdata[CFG_DIM_W-1:0];
                REG_BORDER_MARGIN: cfg_reg.border_margin <= pwdata[MARGIN_W-1:0];
                REG_HIGH_THRESH:   cfg_reg.high_thresh   <= pwdata[MAG_W-1:0];
                REG_LOW_THRESH:    cfg_reg.low_thresh    <= pwdata[MAG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_FRAME_WIDTH:   prdata = APB_DATA_W'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT:  prdata = APB_DATA_W'(cfg_reg.frame_height);
            REG_BORDER_MARGIN: prdata = APB_DATA_W'(cfg_reg.border_margin);
            REG_HIGH_THRESH:   prdata = APB_DATA_W'(cfg_reg.high_thresh);
            REG_LOW_THRESH:    prdata = APB_DATA_W'(cfg_reg.low_thresh);
            default:           prdata = '0;
        endcase
    end

endmodule

/* design/cndt_result_fifo.sv */
// Small result queue that decouples the pixel pipeline from the output handshake.
module cndt_result_fifo (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  cndt_pkg::out_t                  push_data,
    output logic [cndt_pkg::FIFO_CNT_W-1:0] count,
    output logic                            m_valid,
    input  logic                            m_ready,
    output cndt_pkg::out_t                  m_data
);
    import cndt_pkg::*;

    out_t                  slot_reg [RES_FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  pop;

    assign m_valid = (count_reg != '0);
    assign m_data  = slot_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    assign count   = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(RES_FIFO_DEPTH - 1)) ? '0
                        : wr_ptr_reg + FIFO_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(RES_FIFO_DEPTH - 1)) ? '0
                        : rd_ptr_reg + FIFO_PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the Canny non-maximum suppression and double-threshold core.
`timescale 1ns / 1ps

module tb_top;
    import cndt_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 100;

    logic aclk;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count = 0;
    int send_idle_pct = 19;
    int recv_idle_pct = 80;
    bit hold_req = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    logic [CFG_DIM_W-1:0] cfg_width = 9'd256;
    logic [CFG_DIM_W-1:0] cfg_height = 9'd256;
    logic [MARGIN_W-1:0]  cfg_margin = 7'd1;
    mag_t                 cfg_high = '0;
    mag_t                 cfg_low = '0;

    mag_t        line_upper [MAX_WIDTH_DEF];
    mag_t        line_middle [MAX_WIDTH_DEF];
    dir_t        line_dir [MAX_WIDTH_DEF];
    mag_t        win [9] = '{default: '0};
    dir_t        dir_prev = DIR_HORZ;
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    out_t        pending_edges [$];

    canny_nonmax_double_threshold_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("canny_nonmax_double_threshold_core verification failed");
        $finish;
    end

    function automatic bit slope_at_most(input longint y, input longint x, input longint k);
        if (x == 0) begin
            return (k > 0) ? (y <= 0) : (y < 0);
        end
        return y * SLOPE_SCALE <= k * x;
    endfunction

    function automatic dir_t gradient_bin(input longint gx, input longint gy);
        bit a;
        bit na;
        bit b;
        bit nb;
        if (gx < 0) begin
            gx = -gx;
            gy = -gy;
        end
        a  = slope_at_most(gy, gx, SLOPE_LO);
        na = slope_at_most(gy, gx, -SLOPE_LO);
        b  = slope_at_most(gy, gx, SLOPE_HI);
        nb = slope_at_most(gy, gx, -SLOPE_HI);
        if (a && !na) begin
            return DIR_HORZ;
        end
        if (!a && b) begin
            return DIR_DIAG_UL;
        end
        if (na && !nb) begin
            return DIR_DIAG_UR;
        end
        return DIR_VERT;
    endfunction

    function automatic void suppress_pixel(input in_t px);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned cr;
        int unsigned cc;
        int unsigned bm;
        int          k;
        mag_t        up;
        mag_t        mid;
        mag_t        centre;
        mag_t        side_a;
        mag_t        side_b;
        dir_t        cdir;
        bit          interior;
        bit          peak;
        out_t        res;
        w = cfg_width;
        h = cfg_height;
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        if (h < MIN_DIM) h = MIN_DIM;
        if (h > HEIGHT_CAP) h = HEIGHT_CAP;
        if (px.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        r = row_pos;
        c = col_pos;

        up = line_upper[c];
        mid = line_middle[c];
        line_upper[c] = mid;
        line_middle[c] = px.grad_mag;
        for (k = 0; k < 3; k++) begin
            win[k * 3] = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = up;
        win[5] = mid;
        win[8] = px.grad_mag;

        cdir = dir_prev;
        dir_prev = line_dir[c];
        line_dir[c] = gradient_bin($signed(px.grad_x), $signed(px.grad_y));

        if (r >= 2 && c >= 2) begin
            centre = win[4];
            case (cdir)
                DIR_HORZ: begin
                    side_a = win[3];
                    side_b = win[5];
                end
                DIR_DIAG_UL: begin
                    side_a = win[0];
                    side_b = win[8];
                end
                DIR_DIAG_UR: begin
                    side_a = win[6];
                    side_b = win[2];
                end
                default: begin
                    side_a = win[1];
                    side_b = win[7];
                end
            endcase
            cr = r - 1;
            cc = c - 1;
            bm = cfg_margin;
            interior = cr >= bm && cc >= bm && cr + bm < h && cc + bm < w;
            peak = interior && centre > side_a && centre > side_b;
            res.is_peak = peak;
            if (!peak) begin
                res.edge_class = EDGE_NONE;
            end else if (centre > cfg_high) begin
                res.edge_class = EDGE_STRONG;
            end else if (centre < cfg_low) begin
                res.edge_class = EDGE_NONE;
            end else begin
                res.edge_class = EDGE_WEAK;
            end
            res.frame_end = (r == h - 1 && c == w - 1);
            pending_edges.push_back(res);
        end

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            suppress_pixel(s_data);
        end
    end

    task automatic report_mismatch(input string field, input int want, input int got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : check_results
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_edges.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected transaction, expected none, got %h", $time, m_data);
                end
            end else begin
                want = pending_edges.pop_front();
                if (m_data.is_peak !== want.is_peak) begin
                    report_mismatch("is_peak", want.is_peak, m_data.is_peak);
                end
                if (m_data.edge_class !== want.edge_class) begin
                    report_mismatch("edge_class", want.edge_class, m_data.edge_class);
                end
                if (m_data.frame_end !== want.frame_end) begin
                    report_mismatch("frame_end", want.frame_end, m_data.frame_end);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input cfg_reg_t sel, input int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (sel)
            REG_FRAME_WIDTH:   cfg_width = value[CFG_DIM_W-1:0];
            REG_FRAME_HEIGHT:  cfg_height = value[CFG_DIM_W-1:0];
            REG_BORDER_MARGIN: cfg_margin = value[MARGIN_W-1:0];
            REG_HIGH_THRESH:   cfg_high = value[MAG_W-1:0];
            REG_LOW_THRESH:    cfg_low = value[MAG_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_frame(input int w, input int h, input int margin,
                             input int high, input int low);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_BORDER_MARGIN, margin);
        write_reg(REG_HIGH_THRESH, high);
        write_reg(REG_LOW_THRESH, low);
    endtask

    task automatic send_pixel(input in_t px);
        s_valid <= 1'b1;
        s_data <= px;
        do @(posedge aclk); while (!s_ready);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    task automatic finish_phase();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_edges.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    function automatic in_t random_pixel(input bit start);
        in_t px;
        int  gx;
        int  gy;
        int  k;
        int  corner [5] = '{-32768, -1, 0, 1, 32767};
        px.frame_start = start;
        case ($urandom_range(3))
            0: begin
                gx = int'($urandom_range(65535)) - 32768;
                gy = int'($urandom_range(65535)) - 32768;
            end
            1: begin
                gx = int'($urandom_range(6)) - 3;
                gy = int'($urandom_range(6)) - 3;
            end
            2: begin
                gx = $urandom_range(1) ? 5000 * int'($urandom_range(2, 1))
                                       : int'($urandom_range(3000, 1));
                k = $urandom_range(1) ? SLOPE_LO : SLOPE_HI;
                gy = gx * k / SLOPE_SCALE + int'($urandom_range(2)) - 1;
                if ($urandom_range(1)) gy = -gy;
                if ($urandom_range(1)) begin
                    gx = -gx;
                    gy = -gy;
                end
            end
            default: begin
                gx = corner[$urandom_range(4)];
                gy = corner[$urandom_range(4)];
            end
        endcase
        px.grad_x = gx[GRAD_W-1:0];
        px.grad_y = gy[GRAD_W-1:0];
        case ($urandom_range(3))
            0: px.grad_mag = mag_t'($urandom_range(131071));
            1: px.grad_mag = mag_t'($urandom_range(7));
            2: px.grad_mag = mag_t'(int'(cfg_high) + int'($urandom_range(2)) - 1);
            default: px.grad_mag = mag_t'(int'(cfg_low) + int'($urandom_range(2)) - 1);
        endcase
        return px;
    endfunction

    function automatic int pick_dim();
        return ($urandom_range(99) < 15) ? int'($urandom_range(2)) : int'($urandom_range(10, 3));
    endfunction

    function automatic int pick_thresh();
        case ($urandom_range(7))
            0: return 0;
            1: return 131071;
            2: return $urandom_range(15);
            default: return $urandom_range(131071);
        endcase
    endfunction

    task automatic test_directed_cases();
        in_t px;
        int  i;
        mag_t mags [7] = '{17'd131071, 17'd0, 17'd40000, 17'd40000, 17'd2000, 17'd60000, 17'd500};
        set_frame(5, 5, 1, 50000, 1000);
        for (i = 0; i < 25; i++) begin
            px.frame_start = (i == 0);
            case (i % 10)
                0: begin px.grad_x = 16'sd10000;  px.grad_y = 16'sd4142;   end
                1: begin px.grad_x = 16'sd10000;  px.grad_y = 16'sd4143;   end
                2: begin px.grad_x = 16'sd10000;  px.grad_y = 16'sd24142;  end
                3: begin px.grad_x = 16'sd10000;  px.grad_y = 16'sd24143;  end
                4: begin px.grad_x = 16'sd10000;  px.grad_y = -16'sd4142;  end
                5: begin px.grad_x = 16'sd10000;  px.grad_y = -16'sd24142; end
                6: begin px.grad_x = 16'sd0;      px.grad_y = 16'sd0;      end
                7: begin px.grad_x = 16'sd0;      px.grad_y = -16'sd7;     end
                8: begin px.grad_x = 16'h8000;    px.grad_y = 16'sd32767;  end
                default: begin px.grad_x = 16'sd32767; px.grad_y = 16'h8000; end
            endcase
            px.grad_mag = mags[(i * 3) % 7];
            send_pixel(px);
        end
        finish_phase();
    endtask

    task automatic test_wide_frame();
        int i;
        set_frame(256, 3, 1, pick_thresh(), pick_thresh());
        for (i = 0; i < 256 * 3 + 5; i++) begin
            send_pixel(random_pixel(i == 0));
        end
        finish_phase();
    endtask

    task automatic test_tall_frame();
        int i;
        set_frame(3, 300, 1, pick_thresh(), pick_thresh());
        for (i = 0; i < 3 * 256; i++) begin
            send_pixel(random_pixel(i == 0));
        end
        finish_phase();
    endtask

    task automatic test_backpressure();
        int i;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_frame(8, 8, 1, pick_thresh(), pick_thresh());
        hold_req = ~hold_req;
        for (i = 0; i < 64; i++) begin
            send_pixel(random_pixel(i == 0));
        end
        finish_phase();
    endtask

    task automatic random_frames(input int item_goal);
        int sent;
        int w;
        int h;
        int margin;
        int frames;
        int f;
        int p;
        int pixels;
        bit start;
        sent = 0;
        while (sent < item_goal) begin
            w = pick_dim();
            h = pick_dim();
            case ($urandom_range(9))
                0: margin = 127;
                1: margin = $urandom_range(127, 1);
                default: margin = $urandom_range(3, 1);
            endcase
            set_frame(w, h, margin, pick_thresh(), pick_thresh());
            pixels = (w < MIN_DIM ? MIN_DIM : w) * (h < MIN_DIM ? MIN_DIM : h);
            frames = $urandom_range(3, 1);
            for (f = 0; f < frames; f++) begin
                for (p = 0; p < pixels; p++) begin
                    if (p == 0) begin
                        start = (f == 0) || ($urandom_range(3) != 0);
                    end else begin
                        start = ($urandom_range(99) < 2);
                    end
                    send_pixel(random_pixel(start));
                    sent++;
                end
            end
            finish_phase();
        end
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 19;
        recv_idle_pct = 80;
        random_frames(80);
        send_idle_pct = 80;
        recv_idle_pct = 19;
        random_frames(80);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_frames(80);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_wide_frame();
        test_tall_frame();
        test_random_traffic();
        test_backpressure();
        do @(posedge aclk); while (pending_edges.size() != 0);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("canny_nonmax_double_threshold_core verification clean");
        end else begin
            $display("canny_nonmax_double_threshold_core verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
design/cndt_pkg.sv
design/cndt_apb_regs.sv
design/cndt_result_fifo.sv
design/canny_nonmax_double_threshold_core.sv
test/tb_top.sv
